// ----- rtl/vab_pkg.sv -----
// Shared types, sizes and constants for the vector angle core.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package vab_pkg;

    // Coordinate format of the operands.
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Derived datapath widths.
    localparam int DIFF_W     = COORD_WIDTH + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int CORD_W     = 30;
    localparam int NORM_W     = (PROD_W > CORD_W) ? PROD_W : CORD_W;
    localparam int NORM_STEPS = $clog2(NORM_W);
    localparam int XY_W       = CORD_W + 4;

    // Angle arithmetic runs at a scale of 2^60.
    localparam int ANG_SCALE    = 60;
    localparam int ANG_W        = 64;
    localparam int CORDIC_STEPS = 40;
    localparam int OUT_W        = FRAC_BITS + 2;
    localparam int ROUND_SH     = ANG_SCALE - FRAC_BITS;

    localparam logic signed [ANG_W-1:0] PI_S60 = 64'sh3243F6A8885A308D;
    localparam logic signed [ANG_W-1:0] ROUND_HALF = ANG_W'(1) << (ROUND_SH - 1);
    localparam logic [OUT_W-1:0] ANGLE_MAX = OUT_W'((PI_S60 + ROUND_HALF) >> ROUND_SH);

    // Register stages from operand capture to the result register.
    localparam int PIPE_DEPTH = 4 + NORM_STEPS + CORDIC_STEPS + 2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_start_x;
        logic signed [COORD_WIDTH-1:0] a_start_y;
        logic signed [COORD_WIDTH-1:0] a_end_x;
        logic signed [COORD_WIDTH-1:0] a_end_y;
        logic signed [COORD_WIDTH-1:0] b_start_x;
        logic signed [COORD_WIDTH-1:0] b_start_y;
        logic signed [COORD_WIDTH-1:0] b_end_x;
        logic signed [COORD_WIDTH-1:0] b_end_y;
    } t_operands;

    typedef struct packed {
        logic [OUT_W-1:0] angle;
        logic             degenerate;
    } t_result;

    // Control that travels alongside the data through every stage.
    typedef struct packed {
        logic valid;
        logic degenerate;
        logic dneg;
    } t_pipe_ctl;

    // Arctangent of 2^-idx at scale 2^60, from the alternating power series.
    // Evaluated at elaboration only.
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic [ANG_W-1:0] acc;
        logic [ANG_W-1:0] term;
        int               e;
        acc = '0;
        if (idx == 0) begin
            acc = ANG_W'(PI_S60 >>> 2);
        end else begin
            for (int k = 0; k < ANG_SCALE; k++) begin
                e = ANG_SCALE - idx * (2 * k + 1);
                if (e >= 0) begin
                    term = (ANG_W'(1) << e) / ANG_W'(2 * k + 1);
                    if (k[0]) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/vab_norm.sv -----
// Pipelined normaliser: shifts cross and dot magnitudes together until the
// larger one has its leading one at the top. Depends on vab_pkg.
`timescale 1ns / 1ps

module vab_norm
    import vab_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  logic [NORM_W-1:0] i_cross,
    input  logic [NORM_W-1:0] i_dot,
    output t_pipe_ctl         o_ctl,
    output logic [CORD_W-1:0] o_x,
    output logic [CORD_W-1:0] o_y
);

    logic [NORM_W-1:0] c_cr  [0:NORM_STEPS];
    logic [NORM_W-1:0] c_dt  [0:NORM_STEPS];
    t_pipe_ctl         c_ctl [0:NORM_STEPS];

    assign c_cr[0]  = i_cross;
    assign c_dt[0]  = i_dot;
    assign c_ctl[0] = i_ctl;

    // Binary search on the leading-zero count, largest step first.
    for (genvar s = 0; s < NORM_STEPS; s++) begin : g_step
        localparam int SH = 1 << (NORM_STEPS - 1 - s);

        logic              top_clear;
        logic [NORM_W-1:0] n_cr;
        logic [NORM_W-1:0] n_dt;
        logic [NORM_W-1:0] r_cr;
        logic [NORM_W-1:0] r_dt;
        t_pipe_ctl         r_ctl;

        always_comb begin
            top_clear = ((c_cr[s] | c_dt[s]) >> (NORM_W - SH)) == '0;
            n_cr      = top_clear ? (c_cr[s] << SH) : c_cr[s];
            n_dt      = top_clear ? (c_dt[s] << SH) : c_dt[s];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else begin
                r_ctl <= c_ctl[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_cr <= n_cr;
            r_dt <= n_dt;
        end

        assign c_cr[s+1]  = r_cr;
        assign c_dt[s+1]  = r_dt;
        assign c_ctl[s+1] = r_ctl;
    end

    // The top bits keep the larger magnitude in [2^29, 2^30); lower bits drop.
    assign o_ctl = c_ctl[NORM_STEPS];
    assign o_x   = c_dt[NORM_STEPS][NORM_W-1 -: CORD_W];
    assign o_y   = c_cr[NORM_STEPS][NORM_W-1 -: CORD_W];

endmodule

// ----- rtl/vab_cordic.sv -----
// Unrolled CORDIC vectoring pipeline, one micro-rotation per register stage.
// Depends on vab_pkg for widths, step count and the arctangent constants.
`timescale 1ns / 1ps

module vab_cordic
    import vab_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  logic [CORD_W-1:0]       i_x,
    input  logic [CORD_W-1:0]       i_y,
    output t_pipe_ctl               o_ctl,
    output logic signed [ANG_W-1:0] o_z
);

    // Shift that truncates towards zero rather than towards minus infinity.
    function automatic logic signed [XY_W-1:0] sym_shr(input logic signed [XY_W-1:0] v,
                                                       input int s);
        logic signed [XY_W-1:0] m;
        m = v[XY_W-1] ? -v : v;
        m = m >>> s;
        return v[XY_W-1] ? -m : m;
    endfunction

    logic signed [XY_W-1:0]  c_x   [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  c_y   [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] c_z   [0:CORDIC_STEPS];
    t_pipe_ctl               c_ctl [0:CORDIC_STEPS];

    assign c_x[0]   = {{(XY_W - CORD_W){1'b0}}, i_x};
    assign c_y[0]   = {{(XY_W - CORD_W){1'b0}}, i_y};
    assign c_z[0]   = '0;
    assign c_ctl[0] = i_ctl;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        localparam logic signed [ANG_W-1:0] ATAN = atan_entry(i);

        logic signed [XY_W-1:0]  xs;
        logic signed [XY_W-1:0]  ys;
        logic signed [XY_W-1:0]  n_x;
        logic signed [XY_W-1:0]  n_y;
        logic signed [ANG_W-1:0] n_z;
        logic signed [XY_W-1:0]  r_x;
        logic signed [XY_W-1:0]  r_y;
        logic signed [ANG_W-1:0] r_z;
        t_pipe_ctl               r_ctl;

        // Once y reaches zero the vector is on the axis and later stages hold.
        always_comb begin
            xs = sym_shr(c_x[i], i);
            ys = sym_shr(c_y[i], i);
            if (c_y[i] == '0) begin
                n_x = c_x[i];
                n_y = c_y[i];
                n_z = c_z[i];
            end else if (!c_y[i][XY_W-1]) begin
                n_x = c_x[i] + ys;
                n_y = c_y[i] - xs;
                n_z = c_z[i] + ATAN;
            end else begin
                n_x = c_x[i] - ys;
                n_y = c_y[i] + xs;
                n_z = c_z[i] - ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else begin
                r_ctl <= c_ctl[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end

        assign c_x[i+1]   = r_x;
        assign c_y[i+1]   = r_y;
        assign c_z[i+1]   = r_z;
        assign c_ctl[i+1] = r_ctl;
    end

    assign o_ctl = c_ctl[CORDIC_STEPS];
    assign o_z   = c_z[CORDIC_STEPS];

endmodule

// ----- rtl/vector_angle_between_core.sv -----
// Vector angle core: unsigned angle between two 2D vectors given by points.
// Depends on vab_pkg, vab_norm and vab_cordic.
`timescale 1ns / 1ps

// The core is a fully pipelined unit that accepts one transaction in every
// clock cycle: busy is tied low, so a transaction is taken at every rising
// edge at which start is high. Each transaction returns exactly one result,
// shown on o_result for a single cycle with o_done high, in the order of
// acceptance. It passes through PIPE_DEPTH register stages of the datapath:
// one for the
// difference vectors, one for the four signed products, one for the cross and
// dot sums, one for their magnitudes, seven for the normalising shift, forty
// for the CORDIC micro-rotations and two for the quadrant fix-up and rounding.
// The receiver cannot hold results off, and the core never holds results
// back; there is no state carried between transactions. The angle is in
// radians as unsigned Q2.16 from 0 to pi. When either vector has zero length
// the angle reads 0 and the degenerate flag is set.

module vector_angle_between_core
    import vab_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_operands i_operands,
    output logic      o_done,
    output t_result   o_result
);

    // ------------------------------------------------------------------
    // Stage 1: difference vectors, exact at one bit wider than a coordinate.
    // ------------------------------------------------------------------
    t_pipe_ctl                n_s1_ctl;
    t_pipe_ctl                r_s1_ctl;
    logic signed [DIFF_W-1:0] n_ax, n_ay, n_bx, n_by;
    logic signed [DIFF_W-1:0] r_ax, r_ay, r_bx, r_by;

    // Every cycle is open to a new transaction.
    assign busy = 1'b0;

    always_comb begin
        n_s1_ctl            = '0;
        n_s1_ctl.valid      = start && !busy;
        n_ax = {i_operands.a_end_x[COORD_WIDTH-1], i_operands.a_end_x}
             - {i_operands.a_start_x[COORD_WIDTH-1], i_operands.a_start_x};
        n_ay = {i_operands.a_end_y[COORD_WIDTH-1], i_operands.a_end_y}
             - {i_operands.a_start_y[COORD_WIDTH-1], i_operands.a_start_y};
        n_bx = {i_operands.b_end_x[COORD_WIDTH-1], i_operands.b_end_x}
             - {i_operands.b_start_x[COORD_WIDTH-1], i_operands.b_start_x};
        n_by = {i_operands.b_end_y[COORD_WIDTH-1], i_operands.b_end_y}
             - {i_operands.b_start_y[COORD_WIDTH-1], i_operands.b_start_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax <= n_ax;
        r_ay <= n_ay;
        r_bx <= n_bx;
        r_by <= n_by;
    end

    // ------------------------------------------------------------------
    // Stage 2: the four products, and detection of a zero-length vector.
    // ------------------------------------------------------------------
    t_pipe_ctl                n_s2_ctl;
    t_pipe_ctl                r_s2_ctl;
    logic signed [PROD_W-1:0] r_p_axby, r_p_aybx, r_p_axbx, r_p_ayby;

    always_comb begin
        n_s2_ctl            = r_s1_ctl;
        n_s2_ctl.degenerate = ((r_ax == '0) && (r_ay == '0))
                           || ((r_bx == '0) && (r_by == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else begin
            r_s2_ctl <= n_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_axby <= PROD_W'(r_ax) * PROD_W'(r_by);
        r_p_aybx <= PROD_W'(r_ay) * PROD_W'(r_bx);
        r_p_axbx <= PROD_W'(r_ax) * PROD_W'(r_bx);
        r_p_ayby <= PROD_W'(r_ay) * PROD_W'(r_by);
    end

    // ------------------------------------------------------------------
    // Stage 3: exact cross and dot products.
    // ------------------------------------------------------------------
    t_pipe_ctl               r_s3_ctl;
    logic signed [SUM_W-1:0] n_cross, n_dot;
    logic signed [SUM_W-1:0] r_cross, r_dot;

    always_comb begin
        n_cross = SUM_W'(r_p_axby) - SUM_W'(r_p_aybx);
        n_dot   = SUM_W'(r_p_axbx) + SUM_W'(r_p_ayby);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl <= '0;
        end else begin
            r_s3_ctl <= r_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cross <= n_cross;
        r_dot   <= n_dot;
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitudes. The sign of the cross product is dropped since
    // the angle is unsigned; the sign of the dot product selects the
    // obtuse half-plane and travels on as dneg.
    // ------------------------------------------------------------------
    t_pipe_ctl               n_s4_ctl;
    t_pipe_ctl               r_s4_ctl;
    logic signed [SUM_W-1:0] cross_abs, dot_abs;
    logic [NORM_W-1:0]       n_cross_mag, n_dot_mag;
    logic [NORM_W-1:0]       r_cross_mag, r_dot_mag;

    always_comb begin
        n_s4_ctl      = r_s3_ctl;
        n_s4_ctl.dneg = r_dot[SUM_W-1];
        cross_abs     = r_cross[SUM_W-1] ? -r_cross : r_cross;
        dot_abs       = r_dot[SUM_W-1] ? -r_dot : r_dot;
        n_cross_mag   = NORM_W'(cross_abs[PROD_W-1:0]);
        n_dot_mag     = NORM_W'(dot_abs[PROD_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl <= '0;
        end else begin
            r_s4_ctl <= n_s4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cross_mag <= n_cross_mag;
        r_dot_mag   <= n_dot_mag;
    end

    // ------------------------------------------------------------------
    // Normalisation and CORDIC vectoring.
    // ------------------------------------------------------------------
    t_pipe_ctl               norm_ctl;
    logic [CORD_W-1:0]       norm_x, norm_y;
    t_pipe_ctl               cord_ctl;
    logic signed [ANG_W-1:0] cord_z;

    vab_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s4_ctl),
        .i_cross (r_cross_mag),
        .i_dot   (r_dot_mag),
        .o_ctl   (norm_ctl),
        .o_x     (norm_x),
        .o_y     (norm_y)
    );

    vab_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (norm_ctl),
        .i_x     (norm_x),
        .i_y     (norm_y),
        .o_ctl   (cord_ctl),
        .o_z     (cord_z)
    );

    // ------------------------------------------------------------------
    // Finishing stage 1: a negative dot product mirrors the angle about
    // pi/2, giving pi minus the first-quadrant angle.
    // ------------------------------------------------------------------
    t_pipe_ctl               r_f1_ctl;
    logic signed [ANG_W-1:0] n_f1_z;
    logic signed [ANG_W-1:0] r_f1_z;

    always_comb begin
        n_f1_z = cord_ctl.dneg ? (PI_S60 - cord_z) : cord_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_ctl <= '0;
        end else begin
            r_f1_ctl <= cord_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_z <= n_f1_z;
    end

    // ------------------------------------------------------------------
    // Finishing stage 2: clamp to [0, pi], round half up to the output
    // precision and register the result.
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0] z_clamped;
    logic signed [ANG_W-1:0] z_rounded;
    t_result                 n_result;
    t_result                 r_result;
    logic                    r_done;

    always_comb begin
        if (r_f1_z[ANG_W-1]) begin
            z_clamped = '0;
        end else if (r_f1_z > PI_S60) begin
            z_clamped = PI_S60;
        end else begin
            z_clamped = r_f1_z;
        end
        z_rounded = z_clamped + ROUND_HALF;

        if (r_f1_ctl.degenerate) begin
            n_result.angle      = '0;
            n_result.degenerate = 1'b1;
        end else begin
            n_result.angle      = z_rounded[ROUND_SH +: OUT_W];
            n_result.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_f1_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- rtl/vab_checker.sv -----
// Port-level checker for the vector angle core, attached by the bind below.
// Depends on vab_pkg and on the port list of vector_angle_between_core.
`timescale 1ns / 1ps

module vab_checker
    import vab_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    // Every accepted transaction is followed by its result strobe on o_done.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_DEPTH o_done)
        else $error("accepted transaction gave no result after the pipeline latency");

    // No result appears without a transaction at the matching earlier edge.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, PIPE_DEPTH))
        else $error("result strobe without a matching transaction");

    // A zero-length vector always reports an angle of zero.
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.degenerate) |-> (o_result.angle == '0))
        else $error("degenerate result with a non-zero angle");

    // The angle never exceeds pi at the output precision.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.angle <= ANGLE_MAX))
        else $error("angle beyond pi");

endmodule

bind vector_angle_between_core vab_checker u_vab_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
